@@ hw/rtl/obc_pkg.sv @@
// ============================================================================
// obc_pkg
// Shared constants, types and helpers of the onset band classifier.
// ============================================================================
package obc_pkg;

    localparam int MAX_BANDS   = 64;
    localparam int MAX_LAG     = 8;
    localparam int BAND_W      = $clog2(MAX_BANDS);
    localparam int BIDX_W      = BAND_W + 1;
    localparam int SLOT_W      = $clog2(MAX_LAG - 1);
    localparam int HIST_DEPTH  = (MAX_LAG - 1) * MAX_BANDS;
    localparam int POS_W       = SLOT_W + BAND_W;
    localparam int ENERGY_W    = 24;
    localparam int SUM_W       = 27;
    localparam int LAG_W       = 4;
    localparam int CLASS_W     = 6;
    localparam int OUT_TDATA_W = 8;
    localparam int QCNT_W      = 2;

    localparam logic [LAG_W-1:0] LAG_RESET = LAG_W'(3);
    localparam logic [LAG_W-1:0] LAG_MIN   = LAG_W'(2);
    localparam logic [LAG_W-1:0] LAG_MAX   = LAG_W'(MAX_LAG);

    typedef enum logic {
        OP_BAND  = 1'b0,
        OP_ONSET = 1'b1
    } op_t;

    // Per-item control carried from the read stage to the update stage
    typedef struct packed {
        logic                band_ok;
        logic                last;
        logic                emit;
        logic                full;
        logic                sum_vld;
        logic                fwd_sum;
        logic                fwd_hist;
        logic [BAND_W-1:0]   idx;
        logic [POS_W-1:0]    pos;
        logic [ENERGY_W-1:0] energy;
    } s1_ctrl_t;

    function automatic logic [LAG_W-1:0] clamp_lag(input logic [LAG_W-1:0] lag);
        logic [LAG_W-1:0] r;
        r = lag;
        if (lag < LAG_MIN)
        begin
            r = LAG_MIN;
        end
        else if (lag > LAG_MAX)
        begin
            r = LAG_MAX;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/obc_result_queue.sv @@
// ============================================================================
// obc_result_queue
// Two-entry result queue in front of the master stream port.
// ============================================================================
module obc_result_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [obc_pkg::CLASS_W-1:0]      push_class,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [obc_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [5:0] onset_class, [7:6] zero
    output logic [obc_pkg::QCNT_W-1:0]       count
);

    logic [obc_pkg::CLASS_W-1:0] entry_reg [2];
    logic                        wr_ptr_reg;
    logic                        wr_ptr_next;
    logic                        rd_ptr_reg;
    logic                        rd_ptr_next;
    logic [obc_pkg::QCNT_W-1:0]  count_reg;
    logic [obc_pkg::QCNT_W-1:0]  count_next;
    logic                        pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {{(obc_pkg::OUT_TDATA_W - obc_pkg::CLASS_W){1'b0}}, entry_reg[rd_ptr_reg]};
    assign count    = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + obc_pkg::QCNT_W'(push) - obc_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_class;
        end
    end

endmodule

@@ hw/rtl/onset_band_classifier_core.sv @@
// ============================================================================
// onset_band_classifier_core
// Per-band windowed energy sums with onset-triggered band classification.
// ============================================================================
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tdata band_energy, tuser operation,
//                                      tlast last_band
//  m_*       out  m_tvalid/m_tready    tdata onset_class
//  cfg_*     in   cfg_valid/cfg_ready  cfg_data lag
//
// One item per cycle while s_tready is high. A result is written into the
// output queue by the update stage that follows the frame-end transfer
// causing it, and shows on m_tvalid from then on: the transfer edge
// registers the window-sum and history memory reads, the next cycle does
// the read-modify-write and best-band compare.
// Back-to-back updates of the same entry are forwarded from the write stage.
// Reset (and a lag write) invalidates the 64 window sums through per-band
// valid flags; no clearing pass is needed. The input stalls only while the
// two-entry output queue could overflow.
// ============================================================================
module onset_band_classifier_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [obc_pkg::ENERGY_W-1:0]       s_tdata,   // [23:0] band_energy
    input  logic                               s_tuser,   // [0] operation
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [obc_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [5:0] onset_class
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [obc_pkg::LAG_W-1:0]          cfg_data
);

    // Architectural control state
    logic [obc_pkg::LAG_W-1:0]     lag_reg;
    logic [obc_pkg::LAG_W-1:0]     lag_next;
    logic [obc_pkg::BIDX_W-1:0]    band_index_reg;
    logic [obc_pkg::BIDX_W-1:0]    band_index_next;
    logic [obc_pkg::SLOT_W-1:0]    frame_slot_reg;
    logic [obc_pkg::SLOT_W-1:0]    frame_slot_next;
    logic [obc_pkg::SLOT_W-1:0]    frames_seen_reg;
    logic [obc_pkg::SLOT_W-1:0]    frames_seen_next;
    logic [obc_pkg::LAG_W-1:0]     countdown_reg;
    logic [obc_pkg::LAG_W-1:0]     countdown_next;
    logic [obc_pkg::MAX_BANDS-1:0] sum_vld_reg;
    logic [obc_pkg::MAX_BANDS-1:0] sum_vld_next;

    // Update stage
    logic                          s1_act_reg;
    obc_pkg::s1_ctrl_t             s1_reg;
    obc_pkg::s1_ctrl_t             s1_next;
    logic [obc_pkg::SUM_W-1:0]     best_sum_reg;
    logic [obc_pkg::SUM_W-1:0]     best_sum_next;
    logic [obc_pkg::BAND_W-1:0]    best_band_reg;
    logic [obc_pkg::BAND_W-1:0]    best_band_next;
    logic [obc_pkg::SUM_W-1:0]     wb_sum_reg;
    logic [obc_pkg::ENERGY_W-1:0]  wb_hist_reg;

    // Memories
    logic [obc_pkg::SUM_W-1:0]     sum_mem  [obc_pkg::MAX_BANDS];
    logic [obc_pkg::ENERGY_W-1:0]  hist_mem [obc_pkg::HIST_DEPTH];
    logic [obc_pkg::SUM_W-1:0]     sum_rd_reg;
    logic [obc_pkg::ENERGY_W-1:0]  hist_rd_reg;

    // Read stage signals
    logic                          in_fire;
    logic                          cfg_fire;
    logic                          is_onset;
    logic [obc_pkg::LAG_W-1:0]     lag_eff;
    logic [obc_pkg::SLOT_W-1:0]    win_len;
    logic                          band_ok;
    logic [obc_pkg::BAND_W-1:0]    rd_idx;
    logic [obc_pkg::POS_W-1:0]     rd_pos;
    logic                          win_full;
    logic [obc_pkg::SLOT_W-1:0]    slot_inc;
    logic [obc_pkg::SLOT_W-1:0]    seen_end;
    logic                          emit;

    // Update stage signals
    logic                          s1_write;
    logic [obc_pkg::SUM_W-1:0]     sum_old;
    logic [obc_pkg::ENERGY_W-1:0]  hist_old;
    logic [obc_pkg::SUM_W-1:0]     sum_new;
    logic [obc_pkg::SUM_W-1:0]     cand_sum;
    logic [obc_pkg::BAND_W-1:0]    cand_band;
    logic                          push;
    logic [obc_pkg::QCNT_W-1:0]    q_count;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = s_tvalid && s_tready;
    assign is_onset  = (obc_pkg::op_t'(s_tuser) == obc_pkg::OP_ONSET);

    // Hold input while a new result could find the queue full
    assign s_tready = (q_count == '0) ||
                      ((q_count == obc_pkg::QCNT_W'(1)) && !(s1_act_reg && s1_reg.emit));

    // ------------------------------------------------------------------
    // Read stage: sequencing state and memory read issue
    // ------------------------------------------------------------------
    always_comb
    begin
        lag_eff  = obc_pkg::clamp_lag(lag_reg);
        win_len  = obc_pkg::SLOT_W'(lag_eff - obc_pkg::LAG_W'(1));
        band_ok  = !band_index_reg[obc_pkg::BIDX_W-1];
        rd_idx   = band_index_reg[obc_pkg::BAND_W-1:0];
        rd_pos   = {frame_slot_reg, rd_idx};
        win_full = (frames_seen_reg >= win_len);
        slot_inc = frame_slot_reg + obc_pkg::SLOT_W'(1);
        seen_end = win_full ? frames_seen_reg : frames_seen_reg + obc_pkg::SLOT_W'(1);
        emit     = (countdown_reg == obc_pkg::LAG_W'(2)) && (seen_end == win_len);

        lag_next         = lag_reg;
        band_index_next  = band_index_reg;
        frame_slot_next  = frame_slot_reg;
        frames_seen_next = frames_seen_reg;
        countdown_next   = countdown_reg;

        if (cfg_fire)
        begin
            lag_next         = cfg_data;
            band_index_next  = '0;
            frame_slot_next  = '0;
            frames_seen_next = '0;
        end
        else if (in_fire)
        begin
            if (is_onset)
            begin
                countdown_next = lag_eff;
            end
            else
            begin
                if (band_ok)
                begin
                    band_index_next = band_index_reg + obc_pkg::BIDX_W'(1);
                end
                if (s_tlast)
                begin
                    band_index_next  = '0;
                    frame_slot_next  = (slot_inc >= win_len) ? '0 : slot_inc;
                    frames_seen_next = seen_end;
                    if (countdown_reg != '0)
                    begin
                        countdown_next = countdown_reg - obc_pkg::LAG_W'(1);
                    end
                end
            end
        end

        s1_next.band_ok  = band_ok;
        s1_next.last     = s_tlast;
        s1_next.emit     = s_tlast && emit;
        s1_next.full     = win_full;
        s1_next.sum_vld  = sum_vld_reg[rd_idx];
        s1_next.fwd_sum  = s1_write && (s1_reg.idx == rd_idx);
        s1_next.fwd_hist = s1_write && (s1_reg.pos == rd_pos);
        s1_next.idx      = rd_idx;
        s1_next.pos      = rd_pos;
        s1_next.energy   = s_tdata;
    end

    // ------------------------------------------------------------------
    // Update stage: read-modify-write of the window sum, best-band track
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_write = s1_act_reg && s1_reg.band_ok;

        sum_old  = s1_reg.fwd_sum  ? wb_sum_reg  :
                   (s1_reg.sum_vld ? sum_rd_reg : '0);
        hist_old = s1_reg.fwd_hist ? wb_hist_reg : hist_rd_reg;
        // Drop the oldest frame once the window is full
        sum_new  = sum_old
                 - (s1_reg.full ? obc_pkg::SUM_W'(hist_old) : '0)
                 + obc_pkg::SUM_W'(s1_reg.energy);

        cand_sum  = best_sum_reg;
        cand_band = best_band_reg;
        if (s1_write && (sum_new > best_sum_reg))
        begin
            cand_sum  = sum_new;
            cand_band = s1_reg.idx;
        end

        push = s1_act_reg && s1_reg.emit;

        best_sum_next  = best_sum_reg;
        best_band_next = best_band_reg;
        sum_vld_next   = sum_vld_reg;
        if (cfg_fire)
        begin
            best_sum_next  = '0;
            best_band_next = '0;
            sum_vld_next   = '0;
        end
        else if (s1_act_reg)
        begin
            best_sum_next  = s1_reg.last ? '0 : cand_sum;
            best_band_next = s1_reg.last ? '0 : cand_band;
            if (s1_write)
            begin
                sum_vld_next[s1_reg.idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_reg         <= obc_pkg::LAG_RESET;
            band_index_reg  <= '0;
            frame_slot_reg  <= '0;
            frames_seen_reg <= '0;
            countdown_reg   <= '0;
            sum_vld_reg     <= '0;
            s1_act_reg      <= 1'b0;
            best_sum_reg    <= '0;
            best_band_reg   <= '0;
        end
        else
        begin
            lag_reg         <= lag_next;
            band_index_reg  <= band_index_next;
            frame_slot_reg  <= frame_slot_next;
            frames_seen_reg <= frames_seen_next;
            countdown_reg   <= countdown_next;
            sum_vld_reg     <= sum_vld_next;
            s1_act_reg      <= in_fire && !is_onset;
            best_sum_reg    <= best_sum_next;
            best_band_reg   <= best_band_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg <= s1_next;
        end
        if (s1_write)
        begin
            wb_sum_reg  <= sum_new;
            wb_hist_reg <= s1_reg.energy;
        end
    end

    // Window sums: read on transfer, written back from the update stage
    always_ff @(posedge clk)
    begin
        if (s1_write)
        begin
            sum_mem[s1_reg.idx] <= sum_new;
        end
        if (in_fire)
        begin
            sum_rd_reg <= sum_mem[rd_idx];
        end
    end

    // Energy history ring
    always_ff @(posedge clk)
    begin
        if (s1_write)
        begin
            hist_mem[s1_reg.pos] <= s1_reg.energy;
        end
        if (in_fire)
        begin
            hist_rd_reg <= hist_mem[rd_pos];
        end
    end

    obc_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_class (cand_band),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .count      (q_count)
    );

endmodule

@@ hw/rtl/obc_port_checker.sv @@
// ============================================================================
// obc_port_checker
// Port-level checks of the onset band classifier, bound to the top level.
// ============================================================================
module obc_port_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               s_tuser,
    input  logic                               s_tlast,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [obc_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Pad bits above the class stay zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[obc_pkg::OUT_TDATA_W-1:obc_pkg::CLASS_W] == '0))
        else $error("nonzero pad bits in result");

    // A fresh result follows an earlier band transfer that ended a frame
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |->
            $past(s_tvalid && s_tready && s_tlast &&
                  (obc_pkg::op_t'(s_tuser) == obc_pkg::OP_BAND), 2))
        else $error("result without a frame end");

    // Input stalls only while a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind onset_band_classifier_core obc_port_checker u_obc_port_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/onset_band_classifier_core_tb.sv @@
// ============================================================================
// onset_band_classifier_core_tb
// Streams band-energy frames and onset events into the classifier and
// compares every onset class against a cycle-free model of the window sums.
// A short directed table comes first, then random frames under several lag
// settings. Both stream sides idle and stall at random.
// ============================================================================
module onset_band_classifier_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENERGY_W     = obc_pkg::ENERGY_W;
    localparam int CLASS_W      = obc_pkg::CLASS_W;
    localparam int OUT_TDATA_W  = obc_pkg::OUT_TDATA_W;
    localparam int LAG_W        = obc_pkg::LAG_W;
    localparam int SUM_W        = obc_pkg::SUM_W;
    localparam int HIST_DEPTH   = obc_pkg::HIST_DEPTH;
    localparam int MAX_BANDS    = obc_pkg::MAX_BANDS;
    localparam int MAX_LAG      = obc_pkg::MAX_LAG;

    localparam int STALL_MAX    = 13;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS  = 90;
    localparam int ITEM_TARGET  = 1050;
    localparam int N_DIR        = 16;
    localparam logic [ENERGY_W-1:0] E_MAX = '1;

    typedef struct packed {
        obc_pkg::op_t        op;
        logic [ENERGY_W-1:0] energy;
        logic                last;
        logic                typed;
        logic                hit;
        logic [CLASS_W-1:0]  cls;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [ENERGY_W-1:0]    s_tdata;   // [23:0] band_energy
    logic                   s_tuser;   // [0] operation
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [5:0] onset_class
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [LAG_W-1:0]       cfg_data;

    // window model state
    logic [LAG_W-1:0]    lag_q;
    logic [ENERGY_W-1:0] energy_ring [HIST_DEPTH];
    bit                  ring_written [HIST_DEPTH];
    logic [SUM_W-1:0]    band_sums [MAX_BANDS];
    logic [2:0]          oldest_slot;
    logic [2:0]          frames_held;
    logic [LAG_W-1:0]    onset_count;
    int                  band_ptr;
    logic [SUM_W-1:0]    top_sum;
    logic [CLASS_W-1:0]  top_band;

    logic [CLASS_W-1:0]  expected_class_q [$];
    int                  fail_count;
    int                  item_count;
    bit                  no_idle;
    int                  stall_left;
    int                  idle_cycles;
    dir_row_t            dir_rows [N_DIR];

    onset_band_classifier_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [LAG_W-1:0] span_of(input logic [LAG_W-1:0] v);
        return (v < 4'd2) ? 4'd2 : ((v > 4'(MAX_LAG)) ? 4'(MAX_LAG) : v);
    endfunction

    task automatic clear_window();
        for (int i = 0; i < MAX_BANDS; i++)
        begin
            band_sums[i] = '0;
        end
        oldest_slot = '0;
        frames_held = '0;
        band_ptr    = 0;
        top_sum     = '0;
        top_band    = '0;
    endtask

    // Advance the window model by one accepted item
    task automatic classify_step(input obc_pkg::op_t op, input logic [ENERGY_W-1:0] e,
                                 input logic last, output bit emit,
                                 output logic [CLASS_W-1:0] cls);
        logic [LAG_W-1:0] win_len;
        logic [SUM_W-1:0] s;
        int               pos;
        win_len = span_of(lag_q) - 4'd1;
        emit    = 1'b0;
        cls     = '0;
        if (op == obc_pkg::OP_ONSET)
        begin
            onset_count = span_of(lag_q);
            return;
        end
        if (band_ptr < MAX_BANDS)
        begin
            pos = int'(oldest_slot) * MAX_BANDS + band_ptr;
            s   = band_sums[band_ptr];
            if (frames_held >= win_len)
            begin
                s = s - SUM_W'(energy_ring[pos]);
            end
            s = s + SUM_W'(e);
            band_sums[band_ptr] = s;
            energy_ring[pos]    = e;
            ring_written[pos]   = 1'b1;
            if (s > top_sum)
            begin
                top_sum  = s;
                top_band = CLASS_W'(band_ptr);
            end
            band_ptr++;
        end
        if (last)
        begin
            oldest_slot = oldest_slot + 3'd1;
            if (oldest_slot >= win_len)
            begin
                oldest_slot = '0;
            end
            if (frames_held < win_len)
            begin
                frames_held = frames_held + 3'd1;
            end
            if (onset_count != '0)
            begin
                onset_count = onset_count - 4'd1;
                if (onset_count == 4'd1 && frames_held == win_len)
                begin
                    emit = 1'b1;
                    cls  = top_band;
                end
            end
            band_ptr = 0;
            top_sum  = '0;
            top_band = '0;
        end
    endtask

    // Largest frame that reads only history entries already written
    function automatic int frame_limit();
        logic [LAG_W-1:0] win_len;
        int               lim;
        win_len = span_of(lag_q) - 4'd1;
        if (frames_held < win_len)
        begin
            return 1000;
        end
        lim = 0;
        while (lim < MAX_BANDS && ring_written[int'(oldest_slot) * MAX_BANDS + lim])
        begin
            lim++;
        end
        return (lim == MAX_BANDS) ? 1000 : lim;
    endfunction

    function automatic logic [ENERGY_W-1:0] pick_energy();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return E_MAX;
            2, 3:    return ENERGY_W'($urandom_range(0, 15));
            default: return ENERGY_W'($urandom);
        endcase
    endfunction

    // Drive one item, hold it until the transfer, then update the model
    task automatic send_item(input obc_pkg::op_t op, input logic [ENERGY_W-1:0] e,
                             input logic last, output bit emit,
                             output logic [CLASS_W-1:0] cls);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= e;
        s_tuser  <= op;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        if (op == obc_pkg::OP_ONSET || band_ptr < MAX_BANDS)
        begin
            item_count++;
        end
        classify_step(op, e, last, emit, cls);
    endtask

    task automatic send_predicted(input obc_pkg::op_t op, input logic [ENERGY_W-1:0] e,
                                  input logic last);
        bit                 emit;
        logic [CLASS_W-1:0] cls;
        send_item(op, e, last, emit, cls);
        if (emit)
        begin
            expected_class_q = {expected_class_q, cls};
        end
    endtask

    task automatic write_lag(input logic [LAG_W-1:0] v);
        s_tvalid <= 1'b0;
        while (expected_class_q.size() != 0)
        begin
            @(posedge clk);
        end
        // let frame ends with no result leave the pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        lag_q = v;
        clear_window();
    endtask

    task automatic run_frames(input int n_items);
        int start;
        int lim;
        int n;
        start = item_count;
        while (item_count - start < n_items)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                no_idle = ~no_idle;
            end
            if (onset_count == '0 ? ($urandom_range(0, 9) < 3) : ($urandom_range(0, 24) == 0))
            begin
                send_predicted(obc_pkg::OP_ONSET, ENERGY_W'($urandom), 1'($urandom));
            end
            lim = frame_limit();
            n = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
            if (n > lim)
            begin
                n = lim;
            end
            for (int b = 0; b < n; b++)
            begin
                if (b > 0 && $urandom_range(0, 29) == 0)
                begin
                    send_predicted(obc_pkg::OP_ONSET, ENERGY_W'($urandom), 1'($urandom));
                end
                send_predicted(obc_pkg::OP_BAND, pick_energy(), (b == n - 1));
            end
        end
    endtask

    // Receiver: draw a stall per result, check each transfer
    always @(posedge clk)
    begin : rx_side
        logic [CLASS_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_class_q.size() == 0)
            begin
                $error("onset_class: unexpected result, actual %0d", m_tdata[CLASS_W-1:0]);
                fail_count++;
            end
            else
            begin
                want = expected_class_q.pop_front();
                if (m_tdata[CLASS_W-1:0] !== want)
                begin
                    $error("onset_class mismatch: expected %0d, actual %0d",
                           want, m_tdata[CLASS_W-1:0]);
                    fail_count++;
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, STALL_MAX);
        end
        else if (stall_left > 0)
        begin
            stall_left--;
        end
        m_tready <= (stall_left == 0);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [LAG_W-1:0]   lag_plan [11];
        bit                 emit;
        logic [CLASS_W-1:0] cls;

        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        fail_count  = 0;
        item_count  = 0;
        no_idle     = 1'b0;
        stall_left  = 0;
        idle_cycles = 0;

        lag_q       = obc_pkg::LAG_RESET;
        onset_count = '0;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            ring_written[i] = 1'b0;
            energy_ring[i]  = '0;
        end
        clear_window();

        // op, energy, last, typed, result, class
        dir_rows = '{
            '{obc_pkg::OP_ONSET, E_MAX,       1'b1, 1'b1, 1'b0, 6'd0},
            '{obc_pkg::OP_BAND,  E_MAX,       1'b0, 1'b1, 1'b0, 6'd0},
            '{obc_pkg::OP_BAND,  24'd0,       1'b1, 1'b1, 1'b0, 6'd0},
            '{obc_pkg::OP_BAND,  24'd0,       1'b0, 1'b1, 1'b0, 6'd0},
            '{obc_pkg::OP_BAND,  E_MAX,       1'b1, 1'b1, 1'b1, 6'd0},  // tie: lower band
            '{obc_pkg::OP_BAND,  24'd0,       1'b1, 1'b1, 1'b0, 6'd0},
            '{obc_pkg::OP_ONSET, 24'd0,       1'b0, 1'b0, 1'b0, 6'd0},
            '{obc_pkg::OP_BAND,  24'd0,       1'b0, 1'b0, 1'b0, 6'd0},
            '{obc_pkg::OP_BAND,  24'd0,       1'b1, 1'b0, 1'b0, 6'd0},
            '{obc_pkg::OP_BAND,  24'd0,       1'b0, 1'b0, 1'b0, 6'd0},
            '{obc_pkg::OP_BAND,  24'd0,       1'b1, 1'b1, 1'b1, 6'd0},  // all-zero window
            '{obc_pkg::OP_BAND,  24'd5,       1'b0, 1'b0, 1'b0, 6'd0},
            '{obc_pkg::OP_ONSET, 24'h123456,  1'b1, 1'b0, 1'b0, 6'd0},  // onset mid-frame
            '{obc_pkg::OP_BAND,  24'd7,       1'b1, 1'b0, 1'b0, 6'd0},
            '{obc_pkg::OP_BAND,  24'd1,       1'b0, 1'b0, 1'b0, 6'd0},
            '{obc_pkg::OP_BAND,  24'd9,       1'b1, 1'b0, 1'b0, 6'd0}
        };
        lag_plan = '{4'd2, 4'd8, 4'd15, 4'd0, 4'd5, 4'd1, 4'd7, 4'd4, 4'd6, 4'd9, 4'd3};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIR; r++)
        begin
            send_item(dir_rows[r].op, dir_rows[r].energy, dir_rows[r].last, emit, cls);
            if (dir_rows[r].typed)
            begin
                emit = dir_rows[r].hit;
                cls  = dir_rows[r].cls;
            end
            if (emit)
            begin
                expected_class_q = {expected_class_q, cls};
            end
        end

        foreach (lag_plan[p])
        begin
            write_lag(lag_plan[p]);
            no_idle = ($urandom_range(0, 3) == 0);
            run_frames(PHASE_ITEMS);
        end
        while (item_count < ITEM_TARGET)
        begin
            write_lag(LAG_W'($urandom_range(0, 15)));
            no_idle = 1'b0;
            run_frames(PHASE_ITEMS);
        end

        s_tvalid <= 1'b0;
        while (expected_class_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_class_q.size() != 0)
        begin
            $error("onset_class: %0d expected results missing", expected_class_q.size());
            fail_count++;
        end

        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ onset_band_classifier_core.f @@
hw/rtl/obc_pkg.sv
hw/rtl/obc_result_queue.sv
hw/rtl/onset_band_classifier_core.sv
hw/rtl/obc_port_checker.sv
tb/onset_band_classifier_core_tb.sv
